// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; each macro expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lps_pkg.sv =====
// Types and constants for the LDPC ping-pong sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lps_pkg;

    typedef enum logic [2:0] {
        ST_SELECT   = 3'd0,
        ST_INIT_ACC = 3'd1,
        ST_INIT_FIN = 3'd2,
        ST_BUF_RST  = 3'd3,
        ST_WAIT_FULL = 3'd4,
        ST_SWAP_ACK = 3'd5,
        ST_DEC_ACC  = 3'd6
    } lps_step_t;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_INIT = 2'd1;
    localparam logic [1:0] PHASE_RUN  = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_SELECT  = 2'd2;

    localparam logic [1:0] BLOCK_MIN = 2'd1;
    localparam logic [1:0] BLOCK_MAX = 2'd2;
    localparam logic [1:0] RATE_NONE = 2'd0;

    localparam int OUT_COUNT_WIDTH = 16;

    typedef struct packed {
        logic buf_start;
        logic swap;
        logic buf_clr;
        logic pingpong;
        logic dec_go;
        logic init_owner;
        logic init_go;
    } lps_flags_t;

    typedef struct packed {
        lps_step_t  step;
        logic [1:0] phase;
        logic [1:0] block;
        logic [1:0] rate;
        lps_flags_t flags;
        logic [1:0] err;
    } lps_state_t;

    typedef struct packed {
        logic enable;
        logic init_accepted;
        logic init_finished;
        logic buffer_acknowledged;
        logic buffer_full;
        logic decode_finished;
        logic decode_accepted;
    } lps_hs_t;

endpackage

// ===== rtl/core/lps_ctrl.sv =====
// Next-state logic of the sequencer: one step of the control machine per transfer.
// Depends on lps_pkg for the state, flag and handshake types.
`timescale 1ns / 1ps

module lps_ctrl
    import lps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  lps_state_t             state,
    input  lps_hs_t                hs,
    input  logic [1:0]             block_sel,
    input  logic [1:0]             rate_sel,
    input  logic [COUNT_WIDTH-1:0] overrun_cnt,
    input  logic [COUNT_WIDTH-1:0] decoded_cnt,
    output lps_state_t             state_next,
    output logic [COUNT_WIDTH-1:0] overrun_cnt_next,
    output logic [COUNT_WIDTH-1:0] decoded_cnt_next
);

    logic sel_ok;

    assign sel_ok = (block_sel == BLOCK_MIN || block_sel == BLOCK_MAX) &&
                    (rate_sel != RATE_NONE);

    always_comb
    begin
        state_next       = state;
        overrun_cnt_next = overrun_cnt;
        decoded_cnt_next = decoded_cnt;
        if (!hs.enable)
        begin
            state_next.step  = ST_SELECT;
            state_next.phase = PHASE_IDLE;
            state_next.block = 2'd0;
            state_next.rate  = 2'd0;
            state_next.flags = '0;
            state_next.err   = ERR_NONE;
        end
        else
        begin
            case (state.step)
                ST_SELECT:
                begin
                    if (sel_ok)
                    begin
                        state_next.phase            = PHASE_INIT;
                        state_next.flags.init_owner = 1'b1;
                        state_next.flags.init_go    = 1'b1;
                        state_next.block            = block_sel;
                        state_next.rate             = rate_sel;
                        state_next.step             = ST_INIT_ACC;
                    end
                    else
                    begin
                        state_next.err = ERR_SELECT;
                    end
                end
                ST_INIT_ACC:
                begin
                    if (hs.init_accepted)
                    begin
                        state_next.flags.init_go = 1'b0;
                        state_next.step          = ST_INIT_FIN;
                    end
                end
                ST_INIT_FIN:
                begin
                    if (hs.init_finished)
                    begin
                        state_next.flags.init_owner = 1'b0;
                        state_next.flags.pingpong   = 1'b0;
                        state_next.flags.buf_start  = 1'b1;
                        state_next.flags.buf_clr    = 1'b1;
                        state_next.step             = ST_BUF_RST;
                    end
                end
                ST_BUF_RST:
                begin
                    if (hs.buffer_acknowledged)
                    begin
                        state_next.flags.buf_clr = 1'b0;
                        state_next.phase         = PHASE_RUN;
                        state_next.step          = ST_WAIT_FULL;
                    end
                end
                ST_WAIT_FULL:
                begin
                    if (hs.buffer_full)
                    begin
                        if (hs.decode_finished)
                        begin
                            decoded_cnt_next = decoded_cnt + 1'b1;
                        end
                        else
                        begin
                            overrun_cnt_next = overrun_cnt + 1'b1;
                            state_next.err   = ERR_OVERRUN;
                        end
                        state_next.flags.pingpong = ~state.flags.pingpong;
                        state_next.flags.swap     = 1'b1;
                        state_next.step           = ST_SWAP_ACK;
                    end
                end
                ST_SWAP_ACK:
                begin
                    if (hs.buffer_acknowledged)
                    begin
                        state_next.flags.dec_go = 1'b1;
                        state_next.step         = ST_DEC_ACC;
                    end
                end
                ST_DEC_ACC:
                begin
                    if (hs.decode_accepted)
                    begin
                        state_next.flags.dec_go = 1'b0;
                        state_next.step         = ST_WAIT_FULL;
                    end
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ldpc_pingpong_sequencer_top.sv =====
// LDPC ping-pong input sequencer.
// Each input transfer carries one clock's worth of sampled handshake signals
// (enable, selections and the initializer, buffer and decoder acknowledges).
// Each accepted input transfer yields exactly one output transfer that shows
// the sequencer's registered outputs after that update.
// The state registers double as the output register, so the result of a
// transfer is offered in the cycle after acceptance.
// One item per cycle is sustained while out_ready stays high, set by the
// single result slot: in_ready is high whenever the output slot is empty or
// is being taken in the same cycle. When the receiver stalls, the output
// holds steady and in_ready drops until the pending result is taken.
// Reset clears the machine to idle, the flags and error code to zero, the
// decoded counter to zero and the overrun counter to all ones, with no
// result pending. The counters are COUNT_WIDTH bits, wrap, and are shown
// sign-extended or truncated to 16 bits.
// Depends on lps_pkg and lps_ctrl.
`timescale 1ns / 1ps

module ldpc_pingpong_sequencer_top
    import lps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               enable,
    input  logic [1:0]         block_sel,
    input  logic [1:0]         rate_sel,
    input  logic               init_accepted,
    input  logic               init_finished,
    input  logic               buffer_acknowledged,
    input  logic               buffer_full,
    input  logic               decode_finished,
    input  logic               decode_accepted,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         latched_block,
    output logic [1:0]         latched_rate,
    output logic [1:0]         run_status,
    output logic [1:0]         error_code,
    output logic signed [15:0] overrun_count,
    output logic signed [15:0] decoded_count,
    output logic               init_go,
    output logic               init_owns_mux,
    output logic               decode_go,
    output logic               pingpong_select,
    output logic               buffer_clear,
    output logic [1:0]         buffer_flags
);

    lps_state_t             state_reg;
    lps_state_t             state_next;
    logic [COUNT_WIDTH-1:0] overrun_cnt_reg;
    logic [COUNT_WIDTH-1:0] overrun_cnt_next;
    logic [COUNT_WIDTH-1:0] decoded_cnt_reg;
    logic [COUNT_WIDTH-1:0] decoded_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   in_xfer;
    lps_hs_t                hs;
    logic signed [31:0]     overrun_ext;
    logic signed [31:0]     decoded_ext;

    assign hs.enable              = enable;
    assign hs.init_accepted       = init_accepted;
    assign hs.init_finished       = init_finished;
    assign hs.buffer_acknowledged = buffer_acknowledged;
    assign hs.buffer_full         = buffer_full;
    assign hs.decode_finished     = decode_finished;
    assign hs.decode_accepted     = decode_accepted;

    lps_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .state            (state_reg),
        .hs               (hs),
        .block_sel        (block_sel),
        .rate_sel         (rate_sel),
        .overrun_cnt      (overrun_cnt_reg),
        .decoded_cnt      (decoded_cnt_reg),
        .state_next       (state_next),
        .overrun_cnt_next (overrun_cnt_next),
        .decoded_cnt_next (decoded_cnt_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            overrun_cnt_reg <= '1;
            decoded_cnt_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                state_reg       <= state_next;
                overrun_cnt_reg <= overrun_cnt_next;
                decoded_cnt_reg <= decoded_cnt_next;
            end
        end
    end

    assign overrun_ext = 32'(signed'(overrun_cnt_reg));
    assign decoded_ext = 32'(signed'(decoded_cnt_reg));

    assign out_valid       = out_valid_reg;
    assign latched_block   = state_reg.block;
    assign latched_rate    = state_reg.rate;
    assign run_status      = state_reg.phase;
    assign error_code      = state_reg.err;
    assign overrun_count   = overrun_ext[OUT_COUNT_WIDTH-1:0];
    assign decoded_count   = decoded_ext[OUT_COUNT_WIDTH-1:0];
    assign init_go         = state_reg.flags.init_go;
    assign init_owns_mux   = state_reg.flags.init_owner;
    assign decode_go       = state_reg.flags.dec_go;
    assign pingpong_select = state_reg.flags.pingpong;
    assign buffer_clear    = state_reg.flags.buf_clr;
    assign buffer_flags    = {state_reg.flags.buf_start, state_reg.flags.swap};

endmodule

// ===== rtl/core/lps_checker.sv =====
// Port-level checks of the LDPC ping-pong sequencer, bound to its top level.
// Depends on assert_macros.svh and lps_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_checker
    import lps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               enable,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         run_status,
    input logic [1:0]         error_code,
    input logic signed [15:0] decoded_count,
    input logic               init_go,
    input logic               decode_go,
    input logic               init_owns_mux,
    input logic [1:0]         buffer_flags
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(decoded_count))
    `ASSERT_NEXT(a_disable_clears, in_valid && in_ready && !enable, out_valid &&
        run_status == PHASE_IDLE && error_code == ERR_NONE && !init_go &&
        !decode_go && !init_owns_mux && buffer_flags == 2'b00)
    `ASSERT_NEXT(a_disable_keeps_count, in_valid && in_ready && !enable,
        decoded_count == $past(decoded_count))
    `ASSERT_ALWAYS(a_go_exclusive, !(init_go && decode_go))

endmodule

bind ldpc_pingpong_sequencer_top lps_checker u_lps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .enable        (enable),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .run_status    (run_status),
    .error_code    (error_code),
    .decoded_count (decoded_count),
    .init_go       (init_go),
    .decode_go     (decode_go),
    .init_owns_mux (init_owns_mux),
    .buffer_flags  (buffer_flags)
);

// ===== bench/lps_sequencer_monitor.sv =====
// Watches both transfer channels of the ping-pong sequencer, predicts each result
// and counts mismatches. Depends on lps_pkg for the step, phase, error and flag types.
`timescale 1ns / 1ps

module lps_sequencer_monitor
    import lps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               enable,
    input  logic [1:0]         block_sel,
    input  logic [1:0]         rate_sel,
    input  logic               init_accepted,
    input  logic               init_finished,
    input  logic               buffer_acknowledged,
    input  logic               buffer_full,
    input  logic               decode_finished,
    input  logic               decode_accepted,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         latched_block,
    input  logic [1:0]         latched_rate,
    input  logic [1:0]         run_status,
    input  logic [1:0]         error_code,
    input  logic signed [15:0] overrun_count,
    input  logic signed [15:0] decoded_count,
    input  logic               init_go,
    input  logic               init_owns_mux,
    input  logic               decode_go,
    input  logic               pingpong_select,
    input  logic               buffer_clear,
    input  logic [1:0]         buffer_flags,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [1:0]  block;
        logic [1:0]  rate;
        logic [1:0]  phase;
        logic [1:0]  err;
        logic [15:0] overruns;
        logic [15:0] decodes;
        logic        init_go;
        logic        init_owner;
        logic        dec_go;
        logic        pingpong;
        logic        buf_clr;
        logic [1:0]  buf_flags;
    } seq_view_t;

    lps_step_t              step_q;
    logic [1:0]             phase_q;
    logic [1:0]             block_q;
    logic [1:0]             rate_q;
    logic [1:0]             err_q;
    lps_flags_t             flags_q;
    logic [COUNT_WIDTH-1:0] overrun_cnt;
    logic [COUNT_WIDTH-1:0] decode_cnt;
    seq_view_t              expected_views[$];
    int                     mismatches;

    function automatic logic [15:0] shown_count(logic [COUNT_WIDTH-1:0] cnt);
        logic signed [COUNT_WIDTH-1:0] s;
        s = cnt;
        return 16'(s);
    endfunction

    task automatic check_field(string field, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seq_view_t view;
        if (!rst_n)
        begin
            step_q      = ST_SELECT;
            phase_q     = PHASE_IDLE;
            block_q     = '0;
            rate_q      = '0;
            err_q       = ERR_NONE;
            flags_q     = '0;
            overrun_cnt = '1;
            decode_cnt  = '0;
            mismatches  = 0;
            expected_views.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected", $time);
                end
                else
                begin
                    view = expected_views.pop_front();
                    check_field("latched_block", longint'(view.block),
                                longint'(latched_block));
                    check_field("latched_rate", longint'(view.rate),
                                longint'(latched_rate));
                    check_field("run_status", longint'(view.phase), longint'(run_status));
                    check_field("error_code", longint'(view.err), longint'(error_code));
                    check_field("overrun_count", longint'($signed(view.overruns)),
                                longint'(overrun_count));
                    check_field("decoded_count", longint'($signed(view.decodes)),
                                longint'(decoded_count));
                    check_field("init_go", longint'(view.init_go), longint'(init_go));
                    check_field("init_owns_mux", longint'(view.init_owner),
                                longint'(init_owns_mux));
                    check_field("decode_go", longint'(view.dec_go), longint'(decode_go));
                    check_field("pingpong_select", longint'(view.pingpong),
                                longint'(pingpong_select));
                    check_field("buffer_clear", longint'(view.buf_clr),
                                longint'(buffer_clear));
                    check_field("buffer_flags", longint'(view.buf_flags),
                                longint'(buffer_flags));
                end
            end

            if (in_valid && in_ready)
            begin
                if (!enable)
                begin
                    step_q  = ST_SELECT;
                    phase_q = PHASE_IDLE;
                    block_q = '0;
                    rate_q  = '0;
                    flags_q = '0;
                    err_q   = ERR_NONE;
                end
                else
                begin
                    case (step_q)
                        ST_SELECT:
                            if ((block_sel == BLOCK_MIN || block_sel == BLOCK_MAX)
                                && rate_sel != RATE_NONE)
                            begin
                                phase_q            = PHASE_INIT;
                                flags_q.init_owner = 1'b1;
                                flags_q.init_go    = 1'b1;
                                block_q            = block_sel;
                                rate_q             = rate_sel;
                                step_q             = ST_INIT_ACC;
                            end
                            else
                                err_q = ERR_SELECT;
                        ST_INIT_ACC:
                            if (init_accepted)
                            begin
                                flags_q.init_go = 1'b0;
                                step_q          = ST_INIT_FIN;
                            end
                        ST_INIT_FIN:
                            if (init_finished)
                            begin
                                flags_q.init_owner = 1'b0;
                                flags_q.pingpong   = 1'b0;
                                flags_q.buf_start  = 1'b1;
                                flags_q.buf_clr    = 1'b1;
                                step_q             = ST_BUF_RST;
                            end
                        ST_BUF_RST:
                            if (buffer_acknowledged)
                            begin
                                flags_q.buf_clr = 1'b0;
                                phase_q         = PHASE_RUN;
                                step_q          = ST_WAIT_FULL;
                            end
                        ST_WAIT_FULL:
                            if (buffer_full)
                            begin
                                if (decode_finished)
                                    decode_cnt = decode_cnt + 1'b1;
                                else
                                begin
                                    overrun_cnt = overrun_cnt + 1'b1;
                                    err_q       = ERR_OVERRUN;
                                end
                                flags_q.pingpong = ~flags_q.pingpong;
                                flags_q.swap     = 1'b1;
                                step_q           = ST_SWAP_ACK;
                            end
                        ST_SWAP_ACK:
                            if (buffer_acknowledged)
                            begin
                                flags_q.dec_go = 1'b1;
                                step_q         = ST_DEC_ACC;
                            end
                        ST_DEC_ACC:
                            if (decode_accepted)
                            begin
                                flags_q.dec_go = 1'b0;
                                step_q         = ST_WAIT_FULL;
                            end
                        default:
                            ;
                    endcase
                end

                view.block      = block_q;
                view.rate       = rate_q;
                view.phase      = phase_q;
                view.err        = err_q;
                view.overruns   = shown_count(overrun_cnt);
                view.decodes    = shown_count(decode_cnt);
                view.init_go    = flags_q.init_go;
                view.init_owner = flags_q.init_owner;
                view.dec_go     = flags_q.dec_go;
                view.pingpong   = flags_q.pingpong;
                view.buf_clr    = flags_q.buf_clr;
                view.buf_flags  = {flags_q.buf_start, flags_q.swap};
                expected_views.push_back(view);
            end

            fail_count <= mismatches + expected_views.size();
            pending    <= expected_views.size();
        end
    end

endmodule

// ===== bench/tb_ldpc_pingpong_sequencer_top.sv =====
// Top of the ping-pong sequencer testbench: clock, reset, handshake sessions and verdict.
// Depends on lps_pkg, ldpc_pingpong_sequencer_top and lps_sequencer_monitor.
`timescale 1ns / 1ps

module tb_ldpc_pingpong_sequencer_top;
    import lps_pkg::*;

    localparam int         ITEM_TARGET = 650;
    localparam int         HOLD_CYCLES = 48;
    localparam logic [1:0] BLOCK_NONE  = 2'd0;
    localparam logic [1:0] BLOCK_TOP   = 2'd3;
    localparam logic [1:0] RATE_MIN    = 2'd1;
    localparam logic [1:0] RATE_MAX    = 2'd3;

    typedef struct packed {
        logic       enable;
        logic [1:0] block_sel;
        logic [1:0] rate_sel;
        logic       init_accepted;
        logic       init_finished;
        logic       buffer_acknowledged;
        logic       buffer_full;
        logic       decode_finished;
        logic       decode_accepted;
    } seq_lines_t;

    localparam int LINE_BITS = $bits(seq_lines_t);

    typedef enum int {
        W_INIT_ACC,
        W_INIT_FIN,
        W_BUF_ACK,
        W_BUF_FULL,
        W_DEC_ACC
    } watch_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_ready = 1'b0;
    seq_lines_t         lines = '0;
    logic               in_ready;
    logic               out_valid;
    logic [1:0]         latched_block;
    logic [1:0]         latched_rate;
    logic [1:0]         run_status;
    logic [1:0]         error_code;
    logic signed [15:0] overrun_count;
    logic signed [15:0] decoded_count;
    logic               init_go;
    logic               init_owns_mux;
    logic               decode_go;
    logic               pingpong_select;
    logic               buffer_clear;
    logic [1:0]         buffer_flags;
    int                 fail_count;
    int                 pending;
    int                 items_sent = 0;
    int                 idle_odds = 0;
    bit                 quiet = 1'b0;
    bit                 hold_request = 1'b0;

    always #5 clk = ~clk;

    ldpc_pingpong_sequencer_top #(
        .COUNT_WIDTH(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .enable(lines.enable),
        .block_sel(lines.block_sel),
        .rate_sel(lines.rate_sel),
        .init_accepted(lines.init_accepted),
        .init_finished(lines.init_finished),
        .buffer_acknowledged(lines.buffer_acknowledged),
        .buffer_full(lines.buffer_full),
        .decode_finished(lines.decode_finished),
        .decode_accepted(lines.decode_accepted),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .latched_block(latched_block),
        .latched_rate(latched_rate),
        .run_status(run_status),
        .error_code(error_code),
        .overrun_count(overrun_count),
        .decoded_count(decoded_count),
        .init_go(init_go),
        .init_owns_mux(init_owns_mux),
        .decode_go(decode_go),
        .pingpong_select(pingpong_select),
        .buffer_clear(buffer_clear),
        .buffer_flags(buffer_flags)
    );

    lps_sequencer_monitor #(
        .COUNT_WIDTH(16)
    ) seq_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .enable(lines.enable),
        .block_sel(lines.block_sel),
        .rate_sel(lines.rate_sel),
        .init_accepted(lines.init_accepted),
        .init_finished(lines.init_finished),
        .buffer_acknowledged(lines.buffer_acknowledged),
        .buffer_full(lines.buffer_full),
        .decode_finished(lines.decode_finished),
        .decode_accepted(lines.decode_accepted),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .latched_block(latched_block),
        .latched_rate(latched_rate),
        .run_status(run_status),
        .error_code(error_code),
        .overrun_count(overrun_count),
        .decoded_count(decoded_count),
        .init_go(init_go),
        .init_owns_mux(init_owns_mux),
        .decode_go(decode_go),
        .pingpong_select(pingpong_select),
        .buffer_clear(buffer_clear),
        .buffer_flags(buffer_flags),
        .fail_count(fail_count),
        .pending(pending)
    );

    function automatic seq_lines_t hs(logic en, logic [1:0] bsel, logic [1:0] rsel,
                                      logic ia, logic ifin, logic back, logic bfull,
                                      logic dfin, logic dacc);
        return {en, bsel, rsel, ia, ifin, back, bfull, dfin, dacc};
    endfunction

    function automatic seq_lines_t random_lines(logic en);
        seq_lines_t it;
        it = LINE_BITS'($urandom());
        it.enable = en;
        return it;
    endfunction

    task automatic offer(seq_lines_t it);
        lines    <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic await_line(watch_t line, logic dec_done);
        seq_lines_t it;
        int         gaps;
        gaps = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int n = 0; n <= gaps; n++)
        begin
            it = random_lines(1'b1);
            case (line)
                W_INIT_ACC: it.init_accepted = (n == gaps);
                W_INIT_FIN: it.init_finished = (n == gaps);
                W_BUF_ACK:  it.buffer_acknowledged = (n == gaps);
                W_BUF_FULL:
                begin
                    it.buffer_full     = (n == gaps);
                    it.decode_finished = dec_done;
                end
                W_DEC_ACC:  it.decode_accepted = (n == gaps);
                default:    ;
            endcase
            offer(it);
        end
    endtask

    task automatic run_session(int blocks);
        seq_lines_t it;
        repeat ($urandom_range(0, 2))
        begin
            it = random_lines(1'b1);
            if ($urandom_range(0, 1))
                it.block_sel = $urandom_range(0, 1) ? BLOCK_TOP : BLOCK_NONE;
            else
                it.rate_sel = RATE_NONE;
            offer(it);
        end
        it           = random_lines(1'b1);
        it.block_sel = 2'($urandom_range(BLOCK_MIN, BLOCK_MAX));
        it.rate_sel  = 2'($urandom_range(RATE_MIN, RATE_MAX));
        offer(it);
        await_line(W_INIT_ACC, 1'b0);
        await_line(W_INIT_FIN, 1'b0);
        await_line(W_BUF_ACK, 1'b0);
        for (int b = 0; b < blocks; b++)
        begin
            if ($urandom_range(0, 24) == 0)
                break;
            await_line(W_BUF_FULL, $urandom_range(0, 3) != 0);
            await_line(W_BUF_ACK, 1'b0);
            await_line(W_DEC_ACC, 1'b0);
        end
        offer(random_lines(1'b0));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(hs(1'b0, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_TOP, 2'd2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_MIN, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_MAX, RATE_MAX, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_TOP, RATE_NONE, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        offer(hs(1'b1, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        offer(hs(1'b0, BLOCK_TOP, RATE_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b1, BLOCK_MIN, RATE_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        offer(hs(1'b0, BLOCK_NONE, RATE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent > ITEM_TARGET - 80);
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 3;
                default: idle_odds = 8;
            endcase
            if (!held && items_sent > 200)
            begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && items_sent > 350)
            begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6)) offer(random_lines(1'($urandom_range(0, 1))));
            else
                run_session($urandom_range(0, 8));
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
